>>> hw/rtl/spr_pkg.sv
package spr_pkg;

  localparam int CHAR_W     = 16;
  localparam int BYTES_W    = 32;
  localparam int CFG_DATA_W = 64;
  localparam int LEN_W      = 4;
  localparam int SLOT_W     = 3;

  typedef logic [2:0] cfg_index_t;

  localparam cfg_index_t CFG_CHAR_WIDE      = 3'd0;
  localparam cfg_index_t CFG_PATTERN_LENGTH = 3'd1;
  localparam cfg_index_t CFG_PATTERN_LOW    = 3'd2;
  localparam cfg_index_t CFG_PATTERN_HIGH   = 3'd3;
  localparam cfg_index_t CFG_REPLACE_LENGTH = 3'd4;
  localparam cfg_index_t CFG_REPLACE_LOW    = 3'd5;
  localparam cfg_index_t CFG_REPLACE_HIGH   = 3'd6;

  typedef struct packed {
    logic [CHAR_W-1:0] in_char;
    logic              is_final;
  } in_word_t;

  typedef struct packed {
    logic [CHAR_W-1:0]  out_char;
    logic               char_valid;
    logic               end_of_run;
    logic [BYTES_W-1:0] out_bytes;
  } out_word_t;

endpackage

>>> hw/rtl/spr_in_if.sv
interface spr_in_if;
  import spr_pkg::*;

  logic     valid;
  logic     ready;
  in_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> hw/rtl/spr_out_if.sv
interface spr_out_if;
  import spr_pkg::*;

  logic      valid;
  logic      ready;
  out_word_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);

endinterface

>>> hw/rtl/stream_pattern_replace_core.sv
// Streaming find-and-replace. One character word enters per cycle unless the core stalls;
// an accepted word waits in an input register, where combinational logic compares the
// character window with the pattern and loads every output word that the character causes
// (zero to MAX_PATTERN) into an output burst register, which drains one word per cycle
// while the output is ready; a character causing at most one output word then does not hold
// the input, and one causing more holds it until the burst register is down to its last
// word. On a final character the window is flushed and the last output word carries
// end_of_run and the byte count of the string; a final character that leaves nothing to
// emit yields a bare end marker. The user writes configuration through cfg_write /
// cfg_index / cfg_data only while no word is in flight; the core does not enforce this.
module stream_pattern_replace_core #(
  parameter int MAX_PATTERN = 8
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              cfg_write,
  input  spr_pkg::cfg_index_t               cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0]    cfg_data,
  spr_in_if.sink                            in_stream,
  spr_out_if.source                         out_stream
);
  import spr_pkg::*;

  localparam int CNT_W = $clog2(MAX_PATTERN + 1);
  localparam int IDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
  localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MAX_PATTERN);

  function automatic logic [CHAR_W-1:0] packed_char(input logic wide,
                                                     input logic [CFG_DATA_W-1:0] lo,
                                                     input logic [CFG_DATA_W-1:0] hi,
                                                     input logic [SLOT_W-1:0] i);
    logic [CHAR_W-1:0] ch;
    if (wide) begin
      if (i[2]) begin
        ch = hi[{i[1:0], 4'b0000} +: 16];
      end else begin
        ch = lo[{i[1:0], 4'b0000} +: 16];
      end
    end else begin
      ch = {8'h00, lo[{i, 3'b000} +: 8]};
    end
    return ch;
  endfunction

  function automatic logic [BYTES_W-1:0] sat_add(input logic [BYTES_W-1:0] a,
                                                 input logic [4:0] b);
    logic [BYTES_W:0] s;
    s = {1'b0, a} + (BYTES_W + 1)'(b);
    return s[BYTES_W] ? {BYTES_W{1'b1}} : s[BYTES_W-1:0];
  endfunction

  logic                  char_wide;
  logic [LEN_W-1:0]      pattern_length;
  logic [CFG_DATA_W-1:0] pattern_low;
  logic [CFG_DATA_W-1:0] pattern_high;
  logic [LEN_W-1:0]      replace_length;
  logic [CFG_DATA_W-1:0] replace_low;
  logic [CFG_DATA_W-1:0] replace_high;

  logic                  pend_valid;
  logic [CHAR_W-1:0]     pend_char;
  logic                  pend_final;

  logic [CHAR_W-1:0]     window [MAX_PATTERN];
  logic [CHAR_W-1:0]     window_next [MAX_PATTERN];
  logic [CNT_W-1:0]      fill;
  logic [CNT_W-1:0]      fill_next;
  logic [BYTES_W-1:0]    emitted;

  logic [CHAR_W-1:0]     q_char [MAX_PATTERN];
  logic [CNT_W-1:0]      q_left;
  logic                  q_bare;
  logic                  q_fin;
  logic                  q_wide;
  logic [BYTES_W-1:0]    q_bytes;

  logic                  out_fire;
  logic                  burst_free;
  logic                  load;

  logic [CNT_W-1:0]      p;
  logic [CNT_W-1:0]      r;
  logic [CHAR_W-1:0]     mask;
  logic [CHAR_W-1:0]     c;
  logic [CNT_W-1:0]      f0;
  logic [CNT_W-1:0]      f;
  logic                  ge;
  logic [CNT_W-1:0]      extra;
  logic [MAX_PATTERN-1:0] hit_bits;
  logic                  match;
  logic [CNT_W-1:0]      k;
  logic [CNT_W-1:0]      rr;
  logic [CNT_W-1:0]      nlist;
  logic [CHAR_W-1:0]     w_ins [MAX_PATTERN];
  logic [CHAR_W-1:0]     list [MAX_PATTERN];
  logic [4:0]            step;

  always_ff @(posedge clk) begin
    if (rst) begin
      char_wide      <= 1'b0;
      pattern_length <= LEN_W'(1);
      pattern_low    <= '0;
      pattern_high   <= '0;
      replace_length <= '0;
      replace_low    <= '0;
      replace_high   <= '0;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_CHAR_WIDE:      char_wide      <= cfg_data[0];
        CFG_PATTERN_LENGTH: pattern_length <= cfg_data[LEN_W-1:0];
        CFG_PATTERN_LOW:    pattern_low    <= cfg_data;
        CFG_PATTERN_HIGH:   pattern_high   <= cfg_data;
        CFG_REPLACE_LENGTH: replace_length <= cfg_data[LEN_W-1:0];
        CFG_REPLACE_LOW:    replace_low    <= cfg_data;
        CFG_REPLACE_HIGH:   replace_high   <= cfg_data;
        default: ;
      endcase
    end
  end

  assign out_fire   = out_stream.valid & out_stream.ready;
  assign burst_free = (q_left == '0) || ((q_left == CNT_W'(1)) && out_fire);
  assign load       = pend_valid && burst_free;

  assign in_stream.ready = !pend_valid || load;

  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (in_stream.valid && in_stream.ready) begin
      pend_valid <= 1'b1;
    end else if (load) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_stream.valid && in_stream.ready) begin
      pend_char  <= in_stream.data.in_char;
      pend_final <= in_stream.data.is_final;
    end
  end

  always_comb begin
    if (pattern_length == '0) begin
      p = CNT_W'(1);
    end else if (pattern_length > MAX_LEN) begin
      p = CNT_W'(MAX_PATTERN);
    end else begin
      p = pattern_length[CNT_W-1:0];
    end
    if (replace_length > LEN_W'(p)) begin
      r = p;
    end else begin
      r = replace_length[CNT_W-1:0];
    end
    mask = char_wide ? 16'hFFFF : 16'h00FF;
    step = char_wide ? 5'd2 : 5'd1;
    c    = pend_char & mask;
    f0   = (fill > CNT_W'(MAX_PATTERN - 1)) ? CNT_W'(MAX_PATTERN - 1) : fill;
    f    = f0 + CNT_W'(1);
    ge   = (f >= p);
    extra = ge ? (f - p) : '0;
  end

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      w_ins[j] = (CNT_W'(j) == f0) ? c : window[j];
    end
  end

  always_comb begin
    int idx;
    logic [CHAR_W-1:0] sel;
    for (int i = 0; i < MAX_PATTERN; i++) begin
      idx = int'(extra) + i;
      sel = '0;
      if (idx < MAX_PATTERN) begin
        sel = w_ins[IDX_W'(idx)];
      end
      hit_bits[i] = (CNT_W'(i) >= p) ||
                    ((sel & mask) ==
                     packed_char(char_wide, pattern_low, pattern_high, SLOT_W'(i)));
    end
    match = ge && (&hit_bits);
  end

  always_comb begin
    if (match) begin
      k         = extra;
      rr        = r;
      fill_next = '0;
    end else if (ge) begin
      k         = pend_final ? f : extra + CNT_W'(1);
      rr        = '0;
      fill_next = pend_final ? '0 : p - CNT_W'(1);
    end else begin
      k         = pend_final ? f : '0;
      rr        = '0;
      fill_next = pend_final ? '0 : f;
    end
    nlist = k + rr;
  end

  always_comb begin
    for (int j = 0; j < MAX_PATTERN; j++) begin
      if (CNT_W'(j) < k) begin
        list[j] = w_ins[j] & mask;
      end else begin
        list[j] = packed_char(char_wide, replace_low, replace_high,
                              SLOT_W'(j - int'(k)));
      end
      if (j + int'(k) < MAX_PATTERN) begin
        window_next[j] = w_ins[IDX_W'(j + int'(k))];
      end else begin
        window_next[j] = w_ins[j];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      window <= window_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      emitted <= '0;
    end else if (load) begin
      fill    <= fill_next;
      emitted <= pend_final ? '0 : sat_add(emitted, 5'(nlist) << char_wide);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q_left <= '0;
    end else if (load) begin
      q_left <= (nlist == '0 && pend_final) ? CNT_W'(1) : nlist;
    end else if (out_fire) begin
      q_left <= q_left - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      q_fin  <= pend_final;
      q_wide <= char_wide;
      if (nlist == '0) begin
        q_bare    <= 1'b1;
        q_char[0] <= '0;
        q_bytes   <= emitted;
        for (int j = 1; j < MAX_PATTERN; j++) begin
          q_char[j] <= list[j];
        end
      end else begin
        q_bare  <= 1'b0;
        q_char  <= list;
        q_bytes <= sat_add(emitted, step);
      end
    end else if (out_fire) begin
      for (int j = 0; j < MAX_PATTERN - 1; j++) begin
        q_char[j] <= q_char[j + 1];
      end
      q_bytes <= sat_add(q_bytes, q_wide ? 5'd2 : 5'd1);
    end
  end

  assign out_stream.valid           = (q_left != '0);
  assign out_stream.data.out_char   = q_char[0];
  assign out_stream.data.char_valid = !q_bare;
  assign out_stream.data.end_of_run = q_fin && (q_left == CNT_W'(1));
  assign out_stream.data.out_bytes  = q_bytes;

endmodule

>>> hw/rtl/spr_checker.sv
module spr_port_checker (
  input logic                          clk,
  input logic                          rst,
  input logic                          out_valid,
  input logic                          out_ready,
  input spr_pkg::out_word_t            out_data
);
  import spr_pkg::*;

  logic               out_acc;
  logic               mid;
  logic [BYTES_W-1:0] prev_bytes;

  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      mid <= 1'b0;
    end else if (out_acc) begin
      mid <= !out_data.end_of_run;
    end
  end

  always_ff @(posedge clk) begin
    if (out_acc) begin
      prev_bytes <= out_data.out_bytes;
    end
  end

  a_marker_ends: assert property (@(posedge clk) disable iff (rst)
    out_acc && !out_data.char_valid |-> out_data.end_of_run)
    else $error("bare marker without end_of_run");

  a_first_count: assert property (@(posedge clk) disable iff (rst)
    out_acc && !mid |->
      (out_data.char_valid && (out_data.out_bytes == 32'd1 || out_data.out_bytes == 32'd2)) ||
      (!out_data.char_valid && out_data.out_bytes == 32'd0))
    else $error("bad byte count on first word of a string");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    out_acc && mid && out_data.char_valid |->
      out_data.out_bytes == prev_bytes + 32'd1 ||
      out_data.out_bytes == prev_bytes + 32'd2 ||
      (prev_bytes == 32'hFFFF_FFFF && out_data.out_bytes == 32'hFFFF_FFFF))
    else $error("byte count does not advance by one character");

  a_marker_count: assert property (@(posedge clk) disable iff (rst)
    out_acc && mid && !out_data.char_valid |-> out_data.out_bytes == prev_bytes)
    else $error("bare marker changes the byte count");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("output word dropped or changed while stalled");

endmodule

bind stream_pattern_replace_core spr_port_checker u_spr_port_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (out_stream.valid),
  .out_ready (out_stream.ready),
  .out_data  (out_stream.data)
);

>>> sim/spr_checker.sv
`timescale 1ns / 100ps

module spr_checker (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  spr_pkg::cfg_index_t            cfg_index,
  input  logic [spr_pkg::CFG_DATA_W-1:0] cfg_data,
  spr_in_if                              in_ch,
  spr_out_if                             out_ch,
  output int                             errors,
  output int                             pending
);
  import spr_pkg::*;

  localparam int WINDOW = 8;

  logic                  wide;
  logic [LEN_W-1:0]      pat_len;
  logic [LEN_W-1:0]      rep_len;
  logic [CFG_DATA_W-1:0] pat_lo, pat_hi, rep_lo, rep_hi;
  logic [CHAR_W-1:0]     window [WINDOW];
  int                    fill;
  logic [BYTES_W-1:0]    run_bytes;
  out_word_t             burst [WINDOW];
  int                    burst_n;
  out_word_t             expected_q [$];

  function automatic logic [CHAR_W-1:0] packed_at(input logic [CFG_DATA_W-1:0] lo,
                                                  input logic [CFG_DATA_W-1:0] hi,
                                                  input int i);
    if (!wide) begin
      return {8'h00, lo[8*i +: 8]};
    end else if (i < 4) begin
      return lo[16*i +: 16];
    end else begin
      return hi[16*(i-4) +: 16];
    end
  endfunction

  function automatic void clear_window();
    foreach (window[i]) window[i] = '0;
    fill = 0;
  endfunction

  function automatic logic [CHAR_W-1:0] shift_out();
    logic [CHAR_W-1:0] oldest;
    oldest = window[0];
    for (int i = 0; i < WINDOW - 1; i++) window[i] = window[i+1];
    window[WINDOW-1] = '0;
    if (fill > 0) fill--;
    return oldest;
  endfunction

  function automatic void push_char(input logic [CHAR_W-1:0] ch);
    logic [BYTES_W-1:0] step;
    step = wide ? 2 : 1;
    run_bytes = (run_bytes > 32'hFFFF_FFFF - step) ? 32'hFFFF_FFFF : run_bytes + step;
    if (burst_n < WINDOW) begin
      burst[burst_n] = '{out_char: ch, char_valid: 1'b1, end_of_run: 1'b0,
                         out_bytes: run_bytes};
      burst_n++;
    end
  endfunction

  task automatic filter_char(input logic [CHAR_W-1:0] raw, input logic fin);
    int                p;
    int                r;
    logic [CHAR_W-1:0] mask;
    logic              hit;
    p = (pat_len < 1) ? 1 : (pat_len > WINDOW) ? WINDOW : pat_len;
    r = (rep_len > p) ? p : rep_len;
    mask = wide ? 16'hFFFF : 16'h00FF;
    burst_n = 0;
    if (fill > WINDOW - 1) fill = WINDOW - 1;
    window[fill] = raw & mask;
    fill++;
    while (fill > p) push_char(shift_out() & mask);
    if (fill == p) begin
      hit = 1'b1;
      for (int i = 0; i < p; i++) begin
        if ((window[i] & mask) != packed_at(pat_lo, pat_hi, i)) hit = 1'b0;
      end
      if (hit) begin
        for (int i = 0; i < r; i++) push_char(packed_at(rep_lo, rep_hi, i));
        clear_window();
      end else begin
        push_char(shift_out() & mask);
      end
    end
    if (fin) begin
      while (fill > 0) push_char(shift_out() & mask);
      if (burst_n == 0) begin
        burst[0] = '{out_char: '0, char_valid: 1'b0, end_of_run: 1'b1, out_bytes: run_bytes};
        burst_n = 1;
      end else begin
        burst[burst_n-1].end_of_run = 1'b1;
      end
      clear_window();
      run_bytes = '0;
    end
    for (int i = 0; i < burst_n; i++) expected_q.push_back(burst[i]);
  endtask

  always @(posedge clk) begin
    out_word_t want;
    out_word_t got;
    if (rst) begin
      wide      = 1'b0;
      pat_len   = 4'd1;
      rep_len   = '0;
      pat_lo    = '0;
      pat_hi    = '0;
      rep_lo    = '0;
      rep_hi    = '0;
      run_bytes = '0;
      clear_window();
      expected_q.delete();
      errors    = 0;
    end else begin
      if (cfg_write) begin
        case (cfg_index)
          CFG_CHAR_WIDE:      wide    = cfg_data[0];
          CFG_PATTERN_LENGTH: pat_len = cfg_data[LEN_W-1:0];
          CFG_PATTERN_LOW:    pat_lo  = cfg_data;
          CFG_PATTERN_HIGH:   pat_hi  = cfg_data;
          CFG_REPLACE_LENGTH: rep_len = cfg_data[LEN_W-1:0];
          CFG_REPLACE_LOW:    rep_lo  = cfg_data;
          CFG_REPLACE_HIGH:   rep_hi  = cfg_data;
          default: ;
        endcase
      end
      if (in_ch.valid && in_ch.ready) begin
        filter_char(in_ch.data.in_char, in_ch.data.is_final);
      end
      if (out_ch.valid && out_ch.ready) begin
        got = out_ch.data;
        if (expected_q.size() == 0) begin
          $display("%0t: unexpected word: expected none, got char %h valid %b end %b bytes %0d",
                   $time, got.out_char, got.char_valid, got.end_of_run, got.out_bytes);
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (got.out_char !== want.out_char || got.char_valid !== want.char_valid ||
              got.end_of_run !== want.end_of_run || got.out_bytes !== want.out_bytes) begin
            $display("%0t: word mismatch: expected char %h valid %b end %b bytes %0d",
                     $time, want.out_char, want.char_valid, want.end_of_run,
                     want.out_bytes);
            $display("%0t:                got      char %h valid %b end %b bytes %0d",
                     $time, got.out_char, got.char_valid, got.end_of_run, got.out_bytes);
            errors++;
          end
        end
      end
    end
    pending = expected_q.size();
  end

endmodule

>>> sim/tb.sv
`timescale 1ns / 100ps

module tb;
  import spr_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_WORDS = 150;

  logic                  clk = 1'b0;
  logic                  rst = 1'b1;
  logic                  cfg_write = 1'b0;
  cfg_index_t            cfg_index = CFG_CHAR_WIDE;
  logic [CFG_DATA_W-1:0] cfg_data = '0;
  int                    errors;
  int                    pending;
  int unsigned           cycles = 0;
  bit                    calm = 1'b0;
  bit                    choke_req = 1'b0;
  bit                    holding = 1'b0;
  int                    random_sent = 0;

  spr_in_if  in_ch ();
  spr_out_if out_ch ();

  stream_pattern_replace_core dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_stream  (in_ch),
    .out_stream (out_ch)
  );

  spr_checker chk (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .errors    (errors),
    .pending   (pending)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || holding) return 0;
    if (roll < 55) return 0;
    if (roll < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  task automatic send_word(input logic [CHAR_W-1:0] ch, input logic fin);
    int gap;
    gap = idle_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.data  <= '{in_char: ch, is_final: fin};
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // hold until every expected word is out, then let the input register settle
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic set_regs(input bit w, input logic [LEN_W-1:0] pl,
                          input logic [CFG_DATA_W-1:0] plo, input logic [CFG_DATA_W-1:0] phi,
                          input logic [LEN_W-1:0] rl,
                          input logic [CFG_DATA_W-1:0] rlo, input logic [CFG_DATA_W-1:0] rhi);
    logic [CFG_DATA_W-1:0] noise;
    noise = {$urandom, $urandom};
    write_reg(CFG_CHAR_WIDE, {noise[CFG_DATA_W-1:1], w});
    write_reg(CFG_PATTERN_LENGTH, {noise[CFG_DATA_W-1:LEN_W], pl});
    write_reg(CFG_PATTERN_LOW, plo);
    write_reg(CFG_PATTERN_HIGH, phi);
    write_reg(CFG_REPLACE_LENGTH, {noise[CFG_DATA_W-1:LEN_W], rl});
    write_reg(CFG_REPLACE_LOW, rlo);
    write_reg(CFG_REPLACE_HIGH, rhi);
    cfg_write <= 1'b0;
  endtask

  task automatic random_phase(input bit squeeze);
    logic [CHAR_W-1:0]     alpha [3];
    logic [CHAR_W-1:0]     pc [8];
    logic [CFG_DATA_W-1:0] plo, phi, rlo, rhi;
    logic [CHAR_W-1:0]     text [$];
    logic [LEN_W-1:0]      pl, rl;
    bit                    w;
    bit                    open_end;
    int                    p, nalpha, nstr, nchunk, roll, cut;
    w = $urandom_range(0, 1);
    nalpha = $urandom_range(1, 3);
    foreach (alpha[i]) begin
      roll = $urandom_range(0, 9);
      alpha[i] = (roll == 0) ? 16'hFFFF : (roll == 1) ? 16'h0000 : 16'($urandom);
      if (!w) alpha[i][15:8] = 8'h00;
    end
    plo = {$urandom, $urandom};
    phi = {$urandom, $urandom};
    rlo = {$urandom, $urandom};
    rhi = {$urandom, $urandom};
    for (int i = 0; i < 8; i++) begin
      pc[i] = alpha[$urandom_range(0, nalpha - 1)];
      if (!w) plo[8*i +: 8] = pc[i][7:0];
      else if (i < 4) plo[16*i +: 16] = pc[i];
      else phi[16*(i-4) +: 16] = pc[i];
    end
    roll = $urandom_range(0, 9);
    pl = (roll == 0) ? 4'd0 : (roll == 1) ? 4'd15 : 4'($urandom_range(1, 8));
    p = (pl == 0) ? 1 : (pl > 8) ? 8 : pl;
    roll = $urandom_range(0, 9);
    rl = (roll < 2) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, p));
    calm <= ($urandom_range(0, 3) == 0);
    set_regs(w, pl, plo, phi, rl, rlo, rhi);
    if (squeeze) begin
      choke_req <= 1'b1;
      while (!holding) @(posedge clk);
    end
    nstr = squeeze ? 8 : $urandom_range(1, 4);
    open_end = ($urandom_range(0, 5) == 0);
    for (int s = 0; s < nstr; s++) begin
      text.delete();
      nchunk = $urandom_range(1, 4);
      for (int k = 0; k < nchunk; k++) begin
        roll = $urandom_range(0, 99);
        cut = (roll < 45 || p == 1) ? p : $urandom_range(1, p - 1);
        if (roll < 65) begin
          for (int i = 0; i < cut; i++) text.push_back(pc[i]);
        end else if (roll < 90) begin
          text.push_back(alpha[$urandom_range(0, nalpha - 1)]);
        end else begin
          text.push_back(16'($urandom));
        end
      end
      for (int i = 0; i < text.size(); i++) begin
        send_word(w ? text[i] : {8'($urandom), text[i][7:0]},
                  (i == text.size() - 1) && !(open_end && s == nstr - 1));
        random_sent++;
      end
    end
    drain();
  endtask

  initial begin
    int n;
    bit held;
    held = 1'b0;
    out_ch.ready <= 1'b0;
    while (rst) @(posedge clk);
    forever begin
      if (choke_req && !held) begin
        held = 1'b1;
        holding <= 1'b1;
        out_ch.ready <= 1'b0;
        repeat (200) @(posedge clk);
        holding <= 1'b0;
      end else begin
        n = idle_gap();
        if (n > 0) begin
          out_ch.ready <= 1'b0;
          repeat (n) @(posedge clk);
        end
      end
      out_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  end

  initial begin
    int phase;
    in_ch.valid <= 1'b0;
    in_ch.data  <= '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // narrow match on the final word, upper byte ignored
    set_regs(1'b0, 4'd3, 64'h0000_0000_0063_6261, 64'h0, 4'd2, 64'h5958, 64'h0);
    send_word(16'hFF61, 1'b0);
    send_word(16'h0062, 1'b0);
    send_word(16'hA563, 1'b1);
    drain();

    // removal leaves a bare end marker; a lone character is flushed
    set_regs(1'b0, 4'd2, 64'h7A7A, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, 64'h0, 64'h0);
    send_word(16'h007A, 1'b0);
    send_word(16'h7A7A, 1'b1);
    send_word(16'hFFFF, 1'b1);
    drain();

    // wide, replacement length set longer than the pattern, clamped to the pattern length
    set_regs(1'b1, 4'd2, 64'h0000_0000_0000_FFFF, 64'h0, 4'd15,
             64'h1357_2468_ACE0_BDF1, 64'hFFFF_FFFF_FFFF_FFFF);
    send_word(16'hFFFF, 1'b0);
    send_word(16'h0000, 1'b0);
    send_word(16'h8001, 1'b1);
    drain();

    // oversized length, full wide pattern and replacement, then leave seven in the window
    set_regs(1'b1, 4'd15, 64'h4444_3333_2222_1111, 64'h8888_7777_6666_5555, 4'd8,
             64'hDDDD_CCCC_BBBB_AAAA, 64'h0F0F_F0F0_EEEE_FFFF);
    for (int i = 0; i < 8; i++) send_word(16'(16'h1111 * (i + 1)), 1'b0);
    for (int i = 0; i < 7; i++) send_word(16'(16'h1111 * (i + 1)), 1'b0);
    drain();

    // shrink the pattern below the window fill
    set_regs(1'b1, 4'd0, 64'h0000_0000_0000_9999, 64'h0, 4'd1, 64'h5A5A, 64'h0);
    send_word(16'h9999, 1'b1);
    drain();

    phase = 0;
    while (random_sent < RANDOM_WORDS) begin
      random_phase(phase == 2);
      phase++;
    end

    if (errors == 0 && pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
